// ===== hw/rtl/rlmos_pkg.sv =====
// Package for the rectangle move-order sorter.
// Holds the rectangle and cell types, config indexes and the blit-order compare.
// No dependencies.
package rlmos_pkg;

  localparam int MAX_RECTS_DEF = 32;

  // Config register indexes
  localparam logic CFG_MOVE_RIGHT = 1'b0;
  localparam logic CFG_MOVE_DOWN  = 1'b1;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic        [14:0] w;
    logic        [14:0] h;
  } rect_t;

  // One chain cell: occupancy plus rectangle
  typedef struct packed {
    logic  valid;
    rect_t rect;
  } cell_t;

  // Chain control, broadcast to all cells
  typedef struct packed {
    logic load;   // insert the incoming rectangle
    logic shift;  // move every cell one step toward the head
  } ctrl_t;

  // Direction settings
  typedef struct packed {
    logic move_right;
    logic move_down;
  } dir_t;

  // True when a must be blitted strictly before b
  function automatic logic goes_before(rect_t a, rect_t b, dir_t dir);
    logic signed [16:0] a_bot;
    logic signed [16:0] b_bot;
    logic               res;
    a_bot = {a.y[15], a.y} + $signed({2'b00, a.h});
    b_bot = {b.y[15], b.y} + $signed({2'b00, b.h});
    if (a.x != b.x) begin
      res = dir.move_right ? (a.x > b.x) : (a.x < b.x);
    end else if (dir.move_down) begin
      res = (a.y > b.y);
    end else begin
      res = (a_bot < b_bot);
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/rlmos_in_if.sv =====
// Input channel of the move-order sorter: valid/ready plus one rectangle.
// No dependencies.
interface rlmos_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
  logic        [14:0] rect_w;
  logic        [14:0] rect_h;
  logic               is_final;

  modport source (output valid, rect_x, rect_y, rect_w, rect_h, is_final, input ready);
  modport sink   (input valid, rect_x, rect_y, rect_w, rect_h, is_final, output ready);
endinterface

// ===== hw/rtl/rlmos_out_if.sv =====
// Output channel of the move-order sorter: valid/ready plus one sorted rectangle.
// No dependencies.
interface rlmos_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic        [14:0] out_w;
  logic        [14:0] out_h;
  logic               out_last;
  logic               overflowed;

  modport source (output valid, out_x, out_y, out_w, out_h, out_last, overflowed,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_w, out_h, out_last, overflowed,
                  output ready);
endinterface

// ===== hw/rtl/rect_list_move_order_sort_unit.sv =====
// Timing: one rectangle accepted per cycle while collecting; the first sorted
// result is offered the cycle after the final rectangle, then one per cycle
// while the output is ready. Input is held off while the insertion chain drains
// through its head cell.
// Reset: chain emptied, drop flag cleared, move_right and move_down set to 0.
// Depends on rlmos_pkg, rlmos_in_if, rlmos_out_if, rlmos_cell.
module rect_list_move_order_sort_unit #(
  parameter int MAX_RECTS = rlmos_pkg::MAX_RECTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rlmos_in_if.sink    rect_in_i,
  rlmos_out_if.source rect_out_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_data_i
);

  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_DRAIN   = 2'b10
  } state_e;

  state_e           state_q, state_d;
  rlmos_pkg::dir_t  dir_q;
  logic             drop_q, drop_d;
  logic             ovf_q, ovf_d;
  rlmos_pkg::ctrl_t ctrl;
  rlmos_pkg::rect_t new_rect;
  rlmos_pkg::cell_t chain [MAX_RECTS];
  logic [MAX_RECTS-1:0] ins;
  logic [MAX_RECTS-1:0] valid_vec;
  logic             in_acc, out_acc, full;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rlmos_pkg::CFG_MOVE_RIGHT: dir_q.move_right <= cfg_data_i;
        rlmos_pkg::CFG_MOVE_DOWN:  dir_q.move_down  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign new_rect.x = rect_in_i.rect_x;
  assign new_rect.y = rect_in_i.rect_y;
  assign new_rect.w = rect_in_i.rect_w;
  assign new_rect.h = rect_in_i.rect_h;

  assign full    = chain[MAX_RECTS-1].valid;
  assign in_acc  = rect_in_i.valid && rect_in_i.ready;
  assign out_acc = rect_out_o.valid && rect_out_o.ready;

  assign ctrl.load  = in_acc && !full;
  assign ctrl.shift = out_acc;

  // Insertion chain
  for (genvar k = 0; k < MAX_RECTS; k++) begin : g_cell
    rlmos_pkg::cell_t prev_cell, next_cell;
    logic             prev_ins;
    if (k == 0) begin : g_head
      assign prev_cell = '0;
      assign prev_ins  = 1'b0;
    end else begin : g_body
      assign prev_cell = chain[k-1];
      assign prev_ins  = ins[k-1];
    end
    if (k == MAX_RECTS - 1) begin : g_tail
      assign next_cell = '0;
    end else begin : g_inner
      assign next_cell = chain[k+1];
    end
    rlmos_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .dir_i       (dir_q),
      .new_rect_i  (new_rect),
      .prev_cell_i (prev_cell),
      .prev_ins_i  (prev_ins),
      .next_cell_i (next_cell),
      .cell_o      (chain[k]),
      .ins_o       (ins[k])
    );
    assign valid_vec[k] = chain[k].valid;
  end

  // Collect / drain sequencing
  always_comb begin
    state_d = state_q;
    drop_d  = drop_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      ST_COLLECT: begin
        if (in_acc) begin
          if (full) begin
            drop_d = 1'b1;
          end
          if (rect_in_i.is_final) begin
            ovf_d   = drop_q || full;
            drop_d  = 1'b0;
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_acc && rect_out_o.out_last) begin
          state_d = ST_COLLECT;
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
      drop_q  <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      drop_q  <= drop_d;
      ovf_q   <= ovf_d;
    end
  end

  // Head cell drives the output
  assign rect_in_i.ready       = (state_q == ST_COLLECT);
  assign rect_out_o.valid      = (state_q == ST_DRAIN);
  assign rect_out_o.out_x      = chain[0].rect.x;
  assign rect_out_o.out_y      = chain[0].rect.y;
  assign rect_out_o.out_w      = chain[0].rect.w;
  assign rect_out_o.out_h      = chain[0].rect.h;
  assign rect_out_o.out_last   = !chain[1].valid;
  assign rect_out_o.overflowed = ovf_q;

`ifndef SYNTH
  // Occupied cells always form a prefix of the chain
  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("chain occupancy has a hole");

  // Draining always has a rectangle at the head
  a_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN |-> chain[0].valid)
    else $error("drain with empty head cell");

  // Last result leaves the chain empty
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && rect_out_o.out_last |=> valid_vec == '0)
    else $error("chain not empty after last result");

  // Input and output never open together
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rect_in_i.ready && rect_out_o.valid))
    else $error("input and output open at once");
`endif

endmodule

// ===== hw/rtl/rlmos_cell.sv =====
// One cell of the insertion chain: holds one rectangle in sorted position.
// Depends on rlmos_pkg.
module rlmos_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rlmos_pkg::ctrl_t      ctrl_i,
  input  rlmos_pkg::dir_t       dir_i,
  input  rlmos_pkg::rect_t      new_rect_i,
  input  rlmos_pkg::cell_t      prev_cell_i,
  input  logic                  prev_ins_i,
  input  rlmos_pkg::cell_t      next_cell_i,
  output rlmos_pkg::cell_t      cell_o,
  output logic                  ins_o
);

  logic             valid_q, valid_d;
  rlmos_pkg::rect_t rect_q, rect_d;

  // New rectangle lands at or before this slot
  assign ins_o = !valid_q || rlmos_pkg::goes_before(new_rect_i, rect_q, dir_i);

  // Shift takes next cell; load takes previous cell or, if it lands here, new one
  always_comb begin
    valid_d = valid_q;
    rect_d  = rect_q;
    if (ctrl_i.shift) begin
      valid_d = next_cell_i.valid;
      rect_d  = next_cell_i.rect;
    end else if (ctrl_i.load) begin
      if (prev_ins_i) begin
        valid_d = prev_cell_i.valid;
        rect_d  = prev_cell_i.rect;
      end else if (ins_o) begin
        valid_d = 1'b1;
        rect_d  = new_rect_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rect_q <= rect_d;
  end

  assign cell_o.valid = valid_q;
  assign cell_o.rect  = rect_q;

endmodule
